@@ hdl/sstf_pkg.sv @@
// Shared types, codes and defaults for the SSTF disk request scheduler.
package sstf_pkg;

    // Default sizing
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_REQUESTERS  = 16;
    localparam int DEF_TRACK_BITS  = 16;

    // Fixed field widths on the ports
    localparam int REQ_W      = 4;
    localparam int TRACK_W    = 16;
    localparam int STATUS_W   = 3;
    localparam int LEFT_W     = 5;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int S_TDATA_W  = 24;  // requester + track, padded to bytes
    localparam int M_TDATA_W  = 32;  // requester + track + full + left, padded

    // Register reset values
    localparam logic [CFG_W-1:0] QUEUE_LIMIT_RST = 5'd16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ACTIVE = 1'b1;

    // Item kinds
    localparam logic OP_ISSUE   = 1'b0;
    localparam logic OP_SERVICE = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ISSUED   = 3'd0,
        ST_SERVED   = 3'd1,
        ST_FULL     = 3'd2,
        ST_BUSY     = 3'd3,
        ST_NOT_FULL = 3'd4
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_COMMIT,
        S_FINISH
    } state_t;

endpackage

@@ hdl/sstf_entry_ram.sv @@
// Request queue storage: one write port, one registered read port.
module sstf_entry_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 21
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/sstf_seek_cmp.sv @@
// Shared seek distance unit: |track - head| and compare against the best so far.
module sstf_seek_cmp #(
    parameter int TW = 16
) (
    input  logic [TW-1:0] head,
    input  logic [TW-1:0] track,
    input  logic [TW-1:0] best_dist,
    input  logic          first,
    output logic [TW-1:0] distance,
    output logic          take
);

    // Absolute difference without overflow
    always_comb begin
        if (track >= head) begin
            distance = track - head;
        end else begin
            distance = head - track;
        end
    end

    // Strictly nearer wins; ties keep the older entry
    assign take = first || (distance < best_dist);

endmodule

@@ hdl/sstf_disk_request_scheduler.sv @@
// Top level of the shortest-seek-time-first disk request scheduler.
//
// Usage:
//   Input stream (s_*): tuser carries the item kind (issue or service), tlast
//   marks a requester's final request, tdata carries requester and track.
//   Output stream (m_*): one result transfer per input transfer; tuser holds
//   the status code, tdata the served requester/track, full flag and the
//   active requester count.
//   Config channel (cfg_*): always ready; write only while the block is idle.
// Sequencing:
//   Issue and refused items go from idle straight to the finish state, which
//   loads the output register. Service: a scan (one queue entry read and compared
//   per cycle on the single distance comparator), then compaction of the queue
//   through the same memory port, then commit and output.
//   s_tready is high only in the idle state, so a new item is not taken until
//   the last one's result is in the output register, plus any output stall.
// Reset: clears the queue, head position, outstanding flags and the active
//   count, and restores queue_limit to 16 and initial_active to 0.
// Stall: the result sits in the output register while m_tready is low; the
//   next item is still accepted, and its result waits until the slot frees.
module sstf_disk_request_scheduler #(
    parameter int QUEUE_DEPTH = sstf_pkg::DEF_QUEUE_DEPTH,
    parameter int REQUESTERS  = sstf_pkg::DEF_REQUESTERS,
    parameter int TRACK_BITS  = sstf_pkg::DEF_TRACK_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input item stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sstf_pkg::S_TDATA_W-1:0] s_tdata,   // [3:0] requester, [19:4] track
    input  logic                           s_tuser,   // [0] op
    input  logic                           s_tlast,   // final_request
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [3:0] served_requester, [19:4] served_track, [20] queue_full,
    // [25:21] requesters_left
    output logic [sstf_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [sstf_pkg::STATUS_W-1:0]  m_tuser,   // [2:0] status
    // Configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sstf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sstf_pkg::CFG_W-1:0]     cfg_data
);

    import sstf_pkg::*;

    localparam int TW    = TRACK_BITS;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int ACW   = $clog2(REQUESTERS + 1);
    localparam int RIW   = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
    localparam int LW_A  = (CW > ACW) ? CW : ACW;
    localparam int LW    = (LW_A > CFG_W) ? LW_A : CFG_W;
    localparam int RXW   = (RIW > REQ_W) ? RIW : REQ_W;
    localparam int ENT_W = REQ_W + TW + 1;

    // Control and state registers
    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    queue_limit_reg, queue_limit_next;
    logic [ACW-1:0]      active_reg, active_next;
    logic [CW-1:0]       pending_reg, pending_next;
    logic [TW-1:0]       head_reg, head_next;
    logic [REQUESTERS-1:0] has_out_reg, has_out_next;

    // Scan and compaction sequencing
    logic [CW-1:0]       scan_idx_reg, scan_idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [CW-1:0]       sh_idx_reg, sh_idx_next;
    logic                shw_valid_reg, shw_valid_next;
    logic [AW-1:0]       shw_idx_reg, shw_idx_next;

    // Best candidate
    logic [AW-1:0]       best_idx_reg, best_idx_next;
    logic [TW-1:0]       best_d_reg, best_d_next;
    logic [REQ_W-1:0]    best_req_reg, best_req_next;
    logic [TW-1:0]       best_trk_reg, best_trk_next;
    logic                best_last_reg, best_last_next;

    // Result staging and output register
    status_t             status_reg, status_next;
    logic [REQ_W-1:0]    res_req_reg, res_req_next;
    logic [TW-1:0]       res_trk_reg, res_trk_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0] m_tuser_reg, m_tuser_next;

    // Memory port
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENT_W-1:0]    ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [ENT_W-1:0]    ram_rdata;

    // Decoded input and misc
    logic                s_xfer, m_xfer, cfg_xfer;
    logic [REQ_W-1:0]    in_req;
    logic [TW-1:0]       in_trk;
    logic [RXW-1:0]      in_req_ext;
    logic [RIW-1:0]      in_req_idx;
    logic                in_req_ok;
    logic [LW-1:0]       limit;
    logic                queue_full;
    logic                scan_done;
    logic                shift_done;
    logic                out_free;
    logic [REQ_W-1:0]    rd_req;
    logic [TW-1:0]       rd_trk;
    logic                rd_last;
    logic [TW-1:0]       seek_dist;
    logic                seek_take;
    logic [RXW-1:0]      best_req_ext;
    logic                best_req_ok;

    // Handshakes
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign s_xfer    = s_tvalid && s_tready;
    assign m_xfer    = m_tvalid_reg && m_tready;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Input field decode
    assign in_req     = s_tdata[REQ_W-1:0];
    assign in_trk     = TW'(s_tdata[REQ_W +: TRACK_W]);
    assign in_req_ext = RXW'(in_req);
    assign in_req_idx = in_req_ext[RIW-1:0];
    assign in_req_ok  = (LW'(in_req) < LW'(REQUESTERS));

    assign best_req_ext = RXW'(best_req_reg);
    assign best_req_ok  = (LW'(best_req_reg) < LW'(REQUESTERS));

    // Full condition: pending reaches min(limit, depth, active)
    always_comb begin
        limit = LW'(queue_limit_reg);
        if (LW'(QUEUE_DEPTH) < limit) begin
            limit = LW'(QUEUE_DEPTH);
        end
        if (LW'(active_reg) < limit) begin
            limit = LW'(active_reg);
        end
    end
    assign queue_full = (LW'(pending_reg) >= limit);

    // Entry unpack
    assign rd_req  = ram_rdata[REQ_W-1:0];
    assign rd_trk  = ram_rdata[REQ_W +: TW];
    assign rd_last = ram_rdata[ENT_W-1];

    assign scan_done  = cmp_valid_reg && (CW'(cmp_idx_reg) == (pending_reg - CW'(1)));
    assign shift_done = (sh_idx_reg >= pending_reg) && !shw_valid_reg;

    // Shared distance comparator
    sstf_seek_cmp #(
        .TW (TW)
    ) u_seek_cmp (
        .head      (head_reg),
        .track     (rd_trk),
        .best_dist (best_d_reg),
        .first     (cmp_idx_reg == '0),
        .distance  (seek_dist),
        .take      (seek_take)
    );

    // Queue storage
    sstf_entry_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .DW    (ENT_W)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser == OP_SERVICE && pending_reg != '0 && queue_full) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (shift_done) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb begin
        queue_limit_next = queue_limit_reg;
        active_next      = active_reg;
        pending_next     = pending_reg;
        head_next        = head_reg;
        has_out_next     = has_out_reg;
        scan_idx_next    = scan_idx_reg;
        cmp_valid_next   = cmp_valid_reg;
        cmp_idx_next     = cmp_idx_reg;
        sh_idx_next      = sh_idx_reg;
        shw_valid_next   = shw_valid_reg;
        shw_idx_next     = shw_idx_reg;
        best_idx_next    = best_idx_reg;
        best_d_next      = best_d_reg;
        best_req_next    = best_req_reg;
        best_trk_next    = best_trk_reg;
        best_last_next   = best_last_reg;
        status_next      = status_reg;
        res_req_next     = res_req_reg;
        res_trk_next     = res_trk_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        ram_we           = 1'b0;
        ram_waddr        = pending_reg[AW-1:0];
        ram_wdata        = {s_tlast, in_trk, in_req};
        ram_raddr        = scan_idx_reg[AW-1:0];

        if (m_xfer) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    res_req_next = '0;
                    res_trk_next = '0;
                    if (s_tuser == OP_ISSUE) begin
                        // Insert at the tail unless full, requester out of range or busy
                        if (queue_full || pending_reg >= CW'(QUEUE_DEPTH)) begin
                            status_next = ST_FULL;
                        end else if (!in_req_ok || has_out_reg[in_req_idx]) begin
                            status_next = ST_BUSY;
                        end else begin
                            ram_we                   = 1'b1;
                            pending_next             = pending_reg + CW'(1);
                            has_out_next[in_req_idx] = 1'b1;
                            status_next              = ST_ISSUED;
                        end
                    end else if (pending_reg == '0 || !queue_full) begin
                        status_next = ST_NOT_FULL;
                    end else begin
                        scan_idx_next  = '0;
                        cmp_valid_next = 1'b0;
                    end
                end
            end
            S_SCAN: begin
                // Read one entry per cycle, compare the one read last cycle
                if (scan_idx_reg < pending_reg) begin
                    scan_idx_next  = scan_idx_reg + CW'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg[AW-1:0];
                end else begin
                    cmp_valid_next = 1'b0;
                end
                if (cmp_valid_reg && seek_take) begin
                    best_idx_next  = cmp_idx_reg;
                    best_d_next    = seek_dist;
                    best_req_next  = rd_req;
                    best_trk_next  = rd_trk;
                    best_last_next = rd_last;
                end
                if (scan_done) begin
                    sh_idx_next    = CW'(best_idx_next) + CW'(1);
                    shw_valid_next = 1'b0;
                end
            end
            S_SHIFT: begin
                // Compact: move entry i+1 down to i, one per cycle
                ram_raddr = sh_idx_reg[AW-1:0];
                if (sh_idx_reg < pending_reg) begin
                    sh_idx_next    = sh_idx_reg + CW'(1);
                    shw_valid_next = 1'b1;
                    shw_idx_next   = AW'(sh_idx_reg - CW'(1));
                end else begin
                    shw_valid_next = 1'b0;
                end
                if (shw_valid_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = shw_idx_reg;
                    ram_wdata = ram_rdata;
                end
            end
            S_COMMIT: begin
                pending_next = pending_reg - CW'(1);
                head_next    = best_trk_reg;
                if (best_req_ok) begin
                    has_out_next[best_req_ext[RIW-1:0]] = 1'b0;
                end
                if (best_last_reg && active_reg != '0) begin
                    active_next = active_reg - ACW'(1);
                end
                status_next  = ST_SERVED;
                res_req_next = best_req_reg;
                res_trk_next = best_trk_reg;
            end
            S_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = M_TDATA_W'({LEFT_W'(active_reg), queue_full,
                                                TRACK_W'(res_trk_reg), res_req_reg});
                end
            end
            default: begin
            end
        endcase

        // Configuration writes
        if (cfg_xfer) begin
            unique case (cfg_index)
                REG_QUEUE_LIMIT: begin
                    queue_limit_next = cfg_data;
                end
                REG_INITIAL_ACTIVE: begin
                    if (LW'(cfg_data) > LW'(REQUESTERS)) begin
                        active_next = ACW'(REQUESTERS);
                    end else begin
                        active_next = ACW'(cfg_data);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            queue_limit_reg <= QUEUE_LIMIT_RST;
            active_reg      <= '0;
            pending_reg     <= '0;
            head_reg        <= '0;
            has_out_reg     <= '0;
            cmp_valid_reg   <= 1'b0;
            shw_valid_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            queue_limit_reg <= queue_limit_next;
            active_reg      <= active_next;
            pending_reg     <= pending_next;
            head_reg        <= head_next;
            has_out_reg     <= has_out_next;
            cmp_valid_reg   <= cmp_valid_next;
            shw_valid_reg   <= shw_valid_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        scan_idx_reg  <= scan_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        sh_idx_reg    <= sh_idx_next;
        shw_idx_reg   <= shw_idx_next;
        best_idx_reg  <= best_idx_next;
        best_d_reg    <= best_d_next;
        best_req_reg  <= best_req_next;
        best_trk_reg  <= best_trk_next;
        best_last_reg <= best_last_next;
        status_reg    <= status_next;
        res_req_reg   <= res_req_next;
        res_trk_reg   <= res_trk_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
